// ----- rtl/pcrrq_pkg.sv -----
// shared types and constants for the paging credit round-robin queue
package pcrrq_pkg;

	localparam int DEF_QUEUE_DEPTH = 16;
	localparam logic [15:0] REFILL_CREDIT = 16'd20;
	localparam logic [3:0] REFILL_TICKS = 4'd10;
	localparam logic [8:0] NEED_OFF = 9'h1FF;
	localparam logic [15:0] DEF_EXPIRY = 16'd120;

	typedef enum logic [1:0] {
		KIND_ADD = 2'd0,
		KIND_STOP = 2'd1,
		KIND_LOAD = 2'd2,
		KIND_TICK = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		CFG_FREE_NEED = 2'd0,
		CFG_ANY_TRAFFIC = 2'd1,
		CFG_HALF_RATE = 2'd2,
		CFG_EXPIRY = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		EV_ADDED = 4'd0,
		EV_DUPLICATE = 4'd1,
		EV_FULL = 4'd2,
		EV_STOPPED = 4'd3,
		EV_NOT_FOUND = 4'd4,
		EV_PAGED = 4'd5,
		EV_EXPIRED = 4'd6,
		EV_BUSY = 4'd7,
		EV_CREDIT_SET = 4'd8,
		EV_TICK_DONE = 4'd9
	} ev_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIND,
		ST_LOAD,
		ST_AGE,
		ST_WORK,
		ST_DONE
	} state_t;

	typedef struct packed {
		kind_t kind;
		logic [31:0] subscriber;
		logic [1:0] channel_need;
		logic [15:0] load_credit;
		logic [7:0] free_signalling;
		logic [7:0] free_full_traffic;
		logic [7:0] free_half_traffic;
	} cmd_t;

	typedef struct packed {
		logic signed [8:0] free_channel_need;
		logic any_uses_traffic;
		logic count_half_rate;
		logic [15:0] expiry_ticks;
	} cfg_t;

	typedef struct packed {
		logic [31:0] subscriber;
		logic [1:0] need;
		logic [7:0] attempts;
		logic [15:0] lifetime;
	} entry_t;

	typedef struct packed {
		logic valid;
		ev_t ev;
		logic [31:0] subscriber;
		logic [1:0] need;
		logic [7:0] attempts;
		logic last;
	} result_t;

endpackage

// ----- rtl/paging_credit_round_robin_queue_top.sv -----
// top level of the paging credit round-robin queue
// Usage:
// Commands enter on start/busy: a transaction is taken at a clock edge with
// start high and busy low; kind selects add, stop, load indication or tick.
// The front end buffers up to two commands; busy rises when both are held.
// Each command yields one or more results, each shown for one cycle with
// strobe high; last marks the final result of a command. The receiver
// cannot stall, so results are never held back.
// A load indication yields its result from ST_LOAD; add and stop scan the
// table one entry per cycle; a tick ages every entry one per cycle, then runs
// a work step if paging is armed or the refill ends, then tick done. The table
// scan sets the throughput: one command at a time. Configuration is written
// through cfg_we/cfg_addr/cfg_wdata while idle; the user must keep to this,
// as the block does not enforce it. Reset empties the table, sets the credit
// to 20, stops the refill and restores defaults; no clearing pass is needed.
module paging_credit_round_robin_queue_top import pcrrq_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_addr,
	input  logic [15:0] cfg_wdata,
	input  logic start,
	output logic busy,
	input  logic [1:0] kind,
	input  logic [31:0] subscriber,
	input  logic [1:0] channel_need,
	input  logic [15:0] load_credit,
	input  logic [7:0] free_signalling,
	input  logic [7:0] free_full_traffic,
	input  logic [7:0] free_half_traffic,
	output logic strobe,
	output logic [3:0] event_res,
	output logic [31:0] subscriber_out,
	output logic [1:0] channel_need_out,
	output logic [7:0] attempt_count,
	output logic last
);

	cfg_t cfg_q;
	cmd_t cmd_in, cmd_b;
	logic avail, pop;
	result_t res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.free_channel_need <= $signed(NEED_OFF);
			cfg_q.any_uses_traffic <= 1'b0;
			cfg_q.count_half_rate <= 1'b0;
			cfg_q.expiry_ticks <= DEF_EXPIRY;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_addr))
				CFG_FREE_NEED: cfg_q.free_channel_need <= $signed(cfg_wdata[8:0]);
				CFG_ANY_TRAFFIC: cfg_q.any_uses_traffic <= cfg_wdata[0];
				CFG_HALF_RATE: cfg_q.count_half_rate <= cfg_wdata[0];
				default: cfg_q.expiry_ticks <= cfg_wdata;
			endcase
		end
	end

	// command bundle
	always_comb begin
		cmd_in.kind = kind_t'(kind);
		cmd_in.subscriber = subscriber;
		cmd_in.channel_need = channel_need;
		cmd_in.load_credit = load_credit;
		cmd_in.free_signalling = free_signalling;
		cmd_in.free_full_traffic = free_full_traffic;
		cmd_in.free_half_traffic = free_half_traffic;
	end

	pcrrq_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd_in(cmd_in),
		.pop(pop),
		.avail(avail),
		.cmd_out(cmd_b)
	);

	pcrrq_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.avail(avail),
		.cmd_in(cmd_b),
		.pop(pop),
		.res(res)
	);

	assign strobe = res.valid;
	assign event_res = res.ev;
	assign subscriber_out = res.subscriber;
	assign channel_need_out = res.need;
	assign attempt_count = res.attempts;
	assign last = res.last;

endmodule

// ----- rtl/pcrrq_front.sv -----
// front end: takes commands and holds them in a two-entry queue
module pcrrq_front import pcrrq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd_in,
	input  logic pop,
	output logic avail,
	output cmd_t cmd_out
);

	cmd_t slot_q [2];
	logic rd_q, wr_q;
	logic [1:0] fill_q;
	logic push;

	assign busy = (fill_q == 2'd2);
	assign push = start && !busy;
	assign avail = (fill_q != 2'd0);
	assign cmd_out = slot_q[rd_q];

	// payload slots
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= cmd_in;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop && avail) begin
				rd_q <= !rd_q;
			end
			if (push && !(pop && avail)) begin
				fill_q <= fill_q + 2'd1;
			end else if (!push && pop && avail) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != 2'd3) else $error("queue fill out of range");
	a_busy_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && !pop) |=> busy) else $error("full queue drained without pop");
	a_empty_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(!avail && !start) |=> !avail) else $error("queue filled without transaction");
`endif

endmodule

// ----- rtl/pcrrq_back.sv -----
// back end: entry table, credit and the sequencer that scans it
module pcrrq_back import pcrrq_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic avail,
	input  cmd_t cmd_in,
	output logic pop,
	output result_t res
);

	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	state_t state_q, state_d;
	cmd_t cmd_q;
	entry_t ent_q [QUEUE_DEPTH];
	logic [CW-1:0] count_q, idx_q;
	logic [15:0] credit_q;
	logic [3:0] refill_q;
	logic armed_q, run_q;

	logic in_range, match, short_ch, traffic;
	entry_t cur, head;
	logic [8:0] ch_count;
	logic [7:0] head_att;
	result_t emit;
	logic shift_en, wr_en;
	logic [CW-1:0] shift_from, wr_idx;
	entry_t wr_data;

	assign in_range = idx_q < count_q;
	assign cur = ent_q[idx_q[IW-1:0]];
	assign head = ent_q[0];
	assign match = cur.subscriber == cmd_q.subscriber;
	assign head_att = (head.attempts == 8'hFF) ? head.attempts : head.attempts + 8'd1;
	assign pop = (state_q == ST_IDLE) && avail;

	// free channel check for the head entry
	always_comb begin
		traffic = (head.need >= 2'd2) || (head.need == 2'd0 && cfg.any_uses_traffic);
		if (traffic) begin
			ch_count = {1'b0, cmd_q.free_full_traffic}
				+ (cfg.count_half_rate ? {1'b0, cmd_q.free_half_traffic} : 9'd0);
		end else begin
			ch_count = {1'b0, cmd_q.free_signalling};
		end
		short_ch = (cfg.free_channel_need != $signed(NEED_OFF))
			&& ($signed({cfg.free_channel_need[8], cfg.free_channel_need})
				> $signed({1'b0, ch_count}));
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (avail) begin
					unique case (cmd_in.kind) inside
						KIND_ADD, KIND_STOP: state_d = ST_FIND;
						KIND_LOAD: state_d = ST_LOAD;
						default: state_d = ST_AGE;
					endcase
				end
			end
			ST_FIND: begin
				if (!in_range || match) begin
					state_d = ST_IDLE;
				end
			end
			ST_LOAD: state_d = ST_IDLE;
			ST_AGE: begin
				if (!in_range) begin
					state_d = (armed_q || refill_q == 4'd1) ? ST_WORK : ST_DONE;
				end
			end
			ST_WORK: state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// results and table write controls
	always_comb begin
		emit = '0;
		emit.ev = EV_ADDED;
		shift_en = 1'b0;
		shift_from = '0;
		wr_en = 1'b0;
		wr_idx = count_q;
		wr_data = cur;
		unique case (state_q)
			ST_FIND: begin
				if (in_range && match) begin
					emit.valid = 1'b1;
					emit.last = 1'b1;
					emit.subscriber = cmd_q.subscriber;
					if (cmd_q.kind == KIND_ADD) begin
						emit.ev = EV_DUPLICATE;
						emit.need = cmd_q.channel_need;
					end else begin
						emit.ev = EV_STOPPED;
						emit.need = cur.need;
						emit.attempts = cur.attempts;
						shift_en = 1'b1;
						shift_from = idx_q;
					end
				end else if (!in_range) begin
					emit.valid = 1'b1;
					emit.last = 1'b1;
					emit.subscriber = cmd_q.subscriber;
					if (cmd_q.kind == KIND_ADD) begin
						emit.need = cmd_q.channel_need;
						if (count_q >= DEPTH_C) begin
							emit.ev = EV_FULL;
						end else begin
							emit.ev = EV_ADDED;
							wr_en = 1'b1;
							wr_idx = count_q;
							wr_data.subscriber = cmd_q.subscriber;
							wr_data.need = cmd_q.channel_need;
							wr_data.attempts = 8'd0;
							wr_data.lifetime = (cfg.expiry_ticks == 16'd0) ? 16'd1
								: cfg.expiry_ticks;
						end
					end else begin
						emit.ev = EV_NOT_FOUND;
					end
				end
			end
			ST_LOAD: begin
				emit.valid = 1'b1;
				emit.last = 1'b1;
				emit.ev = EV_CREDIT_SET;
			end
			ST_AGE: begin
				if (in_range) begin
					if (cur.lifetime <= 16'd1) begin
						emit.valid = 1'b1;
						emit.ev = (cur.attempts != 8'd0) ? EV_EXPIRED : EV_BUSY;
						emit.subscriber = cur.subscriber;
						emit.need = cur.need;
						emit.attempts = cur.attempts;
						shift_en = 1'b1;
						shift_from = idx_q;
					end else begin
						wr_en = 1'b1;
						wr_idx = idx_q;
						wr_data = cur;
						wr_data.lifetime = cur.lifetime - 16'd1;
					end
				end
			end
			ST_WORK: begin
				if (count_q != '0 && credit_q != 16'd0 && !short_ch) begin
					emit.valid = 1'b1;
					emit.ev = EV_PAGED;
					emit.subscriber = head.subscriber;
					emit.need = head.need;
					emit.attempts = head_att;
					shift_en = 1'b1;
					shift_from = '0;
					wr_en = 1'b1;
					wr_idx = count_q - CW'(1);
					wr_data = head;
					wr_data.attempts = head_att;
				end
			end
			ST_DONE: begin
				emit.valid = 1'b1;
				emit.last = 1'b1;
				emit.ev = EV_TICK_DONE;
			end
			default: ;
		endcase
	end

	// entry table: compaction shift plus one write
	always_ff @(posedge clk) begin
		for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
			if (shift_en && CW'(j) >= shift_from && !(wr_en && CW'(j) == wr_idx)) begin
				ent_q[j] <= ent_q[j+1];
			end
		end
		if (wr_en) begin
			ent_q[wr_idx[IW-1:0]] <= wr_data;
		end
		if (pop) begin
			cmd_q <= cmd_in;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q <= '0;
			credit_q <= REFILL_CREDIT;
			refill_q <= 4'd0;
			armed_q <= 1'b0;
			run_q <= 1'b0;
			res <= '0;
		end else begin
			state_q <= state_d;
			res <= emit;
			unique case (state_q)
				ST_IDLE: idx_q <= '0;
				ST_FIND: begin
					if (in_range && !match) begin
						idx_q <= idx_q + CW'(1);
					end
					if (in_range && match && cmd_q.kind == KIND_STOP) begin
						count_q <= count_q - CW'(1);
					end
					if (!in_range && cmd_q.kind == KIND_ADD && count_q < DEPTH_C) begin
						count_q <= count_q + CW'(1);
						armed_q <= 1'b1;
					end
				end
				ST_LOAD: begin
					refill_q <= 4'd0;
					credit_q <= cmd_q.load_credit;
					if (count_q != '0) begin
						armed_q <= 1'b1;
					end
				end
				ST_AGE: begin
					if (in_range) begin
						if (cur.lifetime <= 16'd1) begin
							count_q <= count_q - CW'(1);
						end else begin
							idx_q <= idx_q + CW'(1);
						end
					end else if (refill_q != 4'd0) begin
						refill_q <= refill_q - 4'd1;
						if (refill_q == 4'd1) begin
							credit_q <= REFILL_CREDIT;
						end
					end
					run_q <= armed_q || refill_q == 4'd1;
				end
				ST_WORK: begin
					armed_q <= 1'b0;
					if (count_q != '0) begin
						if (credit_q == 16'd0) begin
							refill_q <= REFILL_TICKS;
						end else begin
							armed_q <= 1'b1;
							if (!short_ch) begin
								credit_q <= credit_q - 16'd1;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C) else $error("entry count above depth");
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |=> !res.valid) else $error("result while idle");
	a_load_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |=> (res.valid && res.last)) else $error("load result lost");
	a_work_ran: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WORK) |-> run_q) else $error("work step without cause");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
// testbench for the paging credit round-robin queue
`timescale 1ns / 100ps

module testbench;
	import pcrrq_pkg::*;

	localparam int DEPTH = DEF_QUEUE_DEPTH;

	typedef struct {
		ev_t ev;
		logic [31:0] sub;
		logic [1:0] need;
		logic [7:0] att;
		logic last;
	} page_event_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_addr = '0;
	logic [15:0] cfg_wdata = '0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] kind = '0;
	logic [31:0] subscriber = '0;
	logic [1:0] channel_need = '0;
	logic [15:0] load_credit = '0;
	logic [7:0] free_signalling = '0;
	logic [7:0] free_full_traffic = '0;
	logic [7:0] free_half_traffic = '0;
	logic strobe;
	logic [3:0] event_res;
	logic [31:0] subscriber_out;
	logic [1:0] channel_need_out;
	logic [7:0] attempt_count;
	logic last;

	// shadow of the paging table and credit logic
	logic [31:0] tbl_sub [DEPTH];
	logic [1:0] tbl_need [DEPTH];
	logic [7:0] tbl_att [DEPTH];
	logic [15:0] tbl_life [DEPTH];
	int tbl_count = 0;
	logic [15:0] sh_credit = REFILL_CREDIT;
	int sh_refill = 0;
	bit sh_armed = 0;
	logic signed [8:0] sh_need_thr = -9'sd1;
	bit sh_any_traffic = 0;
	bit sh_half_rate = 0;
	logic [15:0] sh_expiry = DEF_EXPIRY;

	page_event_t pending_events[$];
	int fails = 0;
	logic [31:0] sub_pool [24];

	paging_credit_round_robin_queue_top dut (.*);

	always #2 clk = ~clk;

	initial begin
		#2ms;
		$display("tb: failure");
		$finish;
	end

	function automatic void push_event(ev_t ev, logic [31:0] s, logic [1:0] nd,
			logic [7:0] at);
		page_event_t e;
		e.ev = ev; e.sub = s; e.need = nd; e.att = at; e.last = 1'b0;
		pending_events.push_back(e);
	endfunction

	function automatic void remove_entry(int idx);
		for (int j = idx; j < tbl_count - 1; j++) begin
			tbl_sub[j] = tbl_sub[j + 1];
			tbl_need[j] = tbl_need[j + 1];
			tbl_att[j] = tbl_att[j + 1];
			tbl_life[j] = tbl_life[j + 1];
		end
		tbl_count--;
	endfunction

	function automatic int find_entry(logic [31:0] s);
		for (int j = 0; j < tbl_count; j++)
			if (tbl_sub[j] == s) return j;
		return -1;
	endfunction

	// one service step: page the head and rotate it, or skip, or start refill
	function automatic void service_head(logic [7:0] sig, logic [7:0] full,
			logic [7:0] half);
		int avail;
		bit traffic;
		logic [31:0] s;
		logic [1:0] nd;
		logic [7:0] at;
		logic [15:0] lt;
		sh_armed = 0;
		if (tbl_count == 0) return;
		if (sh_credit == 0) begin
			sh_refill = REFILL_TICKS;
			return;
		end
		sh_armed = 1;
		traffic = tbl_need[0] >= 2 || (tbl_need[0] == 0 && sh_any_traffic);
		avail = traffic ? int'(full) + (sh_half_rate ? int'(half) : 0) : int'(sig);
		if (sh_need_thr != -9'sd1 && int'(sh_need_thr) > avail) return;
		sh_credit--;
		if (tbl_att[0] != 8'd255) tbl_att[0]++;
		s = tbl_sub[0]; nd = tbl_need[0]; at = tbl_att[0]; lt = tbl_life[0];
		push_event(EV_PAGED, s, nd, at);
		remove_entry(0);
		tbl_sub[tbl_count] = s; tbl_need[tbl_count] = nd;
		tbl_att[tbl_count] = at; tbl_life[tbl_count] = lt;
		tbl_count++;
	endfunction

	// expected events for one accepted command
	function automatic void predict_command(kind_t k, logic [31:0] s, logic [1:0] nd,
			logic [15:0] slots, logic [7:0] sig, logic [7:0] full, logic [7:0] half);
		int idx;
		bit run;
		case (k)
			KIND_ADD: begin
				idx = find_entry(s);
				if (idx >= 0) push_event(EV_DUPLICATE, s, nd, 8'd0);
				else if (tbl_count >= DEPTH) push_event(EV_FULL, s, nd, 8'd0);
				else begin
					tbl_sub[tbl_count] = s; tbl_need[tbl_count] = nd;
					tbl_att[tbl_count] = 8'd0;
					tbl_life[tbl_count] = sh_expiry != 0 ? sh_expiry : 16'd1;
					tbl_count++;
					sh_armed = 1;
					push_event(EV_ADDED, s, nd, 8'd0);
				end
			end
			KIND_STOP: begin
				idx = find_entry(s);
				if (idx >= 0) begin
					push_event(EV_STOPPED, s, tbl_need[idx], tbl_att[idx]);
					remove_entry(idx);
				end else push_event(EV_NOT_FOUND, s, 2'd0, 8'd0);
			end
			KIND_LOAD: begin
				sh_refill = 0;
				sh_credit = slots;
				if (tbl_count != 0) sh_armed = 1;
				push_event(EV_CREDIT_SET, 32'd0, 2'd0, 8'd0);
			end
			default: begin
				run = sh_armed;
				idx = 0;
				while (idx < tbl_count) begin
					if (tbl_life[idx] <= 1) begin
						push_event(tbl_att[idx] != 0 ? EV_EXPIRED : EV_BUSY, tbl_sub[idx],
							tbl_need[idx], tbl_att[idx]);
						remove_entry(idx);
					end else begin
						tbl_life[idx]--;
						idx++;
					end
				end
				if (sh_refill != 0) begin
					sh_refill--;
					if (sh_refill == 0) begin
						sh_credit = REFILL_CREDIT;
						run = 1;
					end
				end
				if (run) service_head(sig, full, half);
				push_event(EV_TICK_DONE, 32'd0, 2'd0, 8'd0);
			end
		endcase
		pending_events[$].last = 1'b1;
	endfunction

	// send one command transaction and predict its events
	task automatic send_command(kind_t k, logic [31:0] s = 0, logic [1:0] nd = 0,
			logic [15:0] slots = 0, logic [7:0] sig = 0, logic [7:0] full = 0,
			logic [7:0] half = 0);
		int gap;
		gap = $urandom_range(0, 10);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		kind <= k; subscriber <= s; channel_need <= nd; load_credit <= slots;
		free_signalling <= sig; free_full_traffic <= full; free_half_traffic <= half;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		predict_command(k, s, nd, slots, sig, full, half);
	endtask

	// drop start and wait until every expected event has been seen
	task automatic drain;
		int guard;
		start <= 1'b0;
		guard = 0;
		while (pending_events.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (DEPTH + 8) @(posedge clk);
	endtask

	// register write once the block has gone quiet
	task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
		drain();
		cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_FREE_NEED: sh_need_thr = val[8:0];
			CFG_ANY_TRAFFIC: sh_any_traffic = val[0];
			CFG_HALF_RATE: sh_half_rate = val[0];
			default: sh_expiry = val;
		endcase
		@(posedge clk);
	endtask

	// compare every result transaction with the oldest expected event
	always @(posedge clk) begin
		page_event_t e;
		if (arst_n && strobe) begin
			if (pending_events.size() == 0) begin
				$error("unexpected result event_res=%0d", event_res);
				fails++;
			end else begin
				e = pending_events.pop_front();
				if (event_res !== e.ev) begin
					$error("event_res exp %0d got %0d", e.ev, event_res); fails++;
				end
				if (subscriber_out !== e.sub) begin
					$error("subscriber_out exp %h got %h", e.sub, subscriber_out); fails++;
				end
				if (channel_need_out !== e.need) begin
					$error("channel_need_out exp %0d got %0d", e.need, channel_need_out);
					fails++;
				end
				if (attempt_count !== e.att) begin
					$error("attempt_count exp %0d got %0d", e.att, attempt_count); fails++;
				end
				if (last !== e.last) begin
					$error("last exp %0d got %0d", e.last, last); fails++;
				end
			end
		end
	end

	// add, duplicate, stop, not found, paging of each channel need
	task automatic test_add_stop;
		send_command(KIND_ADD, 32'h0000_0000, 2'd0);
		send_command(KIND_ADD, 32'hFFFF_FFFF, 2'd3);
		send_command(KIND_ADD, 32'hFFFF_FFFF, 2'd1);
		send_command(KIND_ADD, 32'h5A5A_A5A5, 2'd2);
		send_command(KIND_ADD, 32'hA5A5_5A5A, 2'd1);
		repeat (5) send_command(KIND_TICK, 0, 0, 0, 8'hFF, 8'hFF, 8'hFF);
		send_command(KIND_STOP, 32'h5A5A_A5A5);
		send_command(KIND_STOP, 32'h1234_5678);
		send_command(KIND_LOAD, 0, 0, 16'hFFFF);
		drain();
	endtask

	// table full, then emptied by stops
	task automatic test_full;
		for (int j = 0; j <= DEPTH; j++) send_command(KIND_ADD, 32'h100 + j, j[1:0]);
		for (int j = 0; j <= DEPTH; j++) send_command(KIND_STOP, 32'h100 + j);
		send_command(KIND_STOP, 32'h0000_0000);
		send_command(KIND_STOP, 32'hFFFF_FFFF);
		send_command(KIND_STOP, 32'hA5A5_5A5A);
		drain();
	endtask

	// zero lifetime acts as one; expiry of paged and never paged entries
	task automatic test_expiry;
		write_reg(CFG_FREE_NEED, 16'h00FF);
		write_reg(CFG_EXPIRY, 16'd0);
		send_command(KIND_ADD, 32'h77, 2'd1);
		send_command(KIND_TICK, 0, 0, 0, 8'd0);
		write_reg(CFG_FREE_NEED, 16'h01FF);
		write_reg(CFG_EXPIRY, 16'd2);
		send_command(KIND_ADD, 32'h88, 2'd2);
		send_command(KIND_TICK);
		send_command(KIND_TICK);
		drain();
	endtask

	// zero credit starts the refill, ten ticks later paging resumes
	task automatic test_refill;
		write_reg(CFG_EXPIRY, 16'd200);
		send_command(KIND_LOAD, 0, 0, 16'd0);
		send_command(KIND_ADD, 32'h99, 2'd0);
		repeat (12) send_command(KIND_TICK);
		send_command(KIND_LOAD, 0, 0, 16'd0);
		send_command(KIND_TICK);
		send_command(KIND_LOAD, 0, 0, 16'd3);
		repeat (4) send_command(KIND_TICK);
		send_command(KIND_STOP, 32'h99);
		drain();
	endtask

	// channel threshold, traffic counting options, negative thresholds
	task automatic test_threshold;
		write_reg(CFG_FREE_NEED, 16'd4);
		write_reg(CFG_ANY_TRAFFIC, 16'd1);
		write_reg(CFG_HALF_RATE, 16'd1);
		send_command(KIND_LOAD, 0, 0, 16'd100);
		for (int j = 0; j < 4; j++) send_command(KIND_ADD, 32'h200 + j, j[1:0]);
		send_command(KIND_TICK, 0, 0, 0, 8'd9, 8'd2, 8'd2);
		send_command(KIND_TICK, 0, 0, 0, 8'd3, 8'd2, 8'd1);
		write_reg(CFG_HALF_RATE, 16'd0);
		send_command(KIND_TICK, 0, 0, 0, 8'd4, 8'd3, 8'd9);
		write_reg(CFG_ANY_TRAFFIC, 16'd0);
		write_reg(CFG_FREE_NEED, 16'h0100);
		send_command(KIND_TICK, 0, 0, 0, 8'd0, 8'd0, 8'd0);
		write_reg(CFG_FREE_NEED, 16'h01FB);
		send_command(KIND_TICK, 0, 0, 0, 8'd0, 8'd0, 8'd0);
		for (int j = 0; j < 4; j++) send_command(KIND_STOP, 32'h200 + j);
		drain();
	endtask

	// random phases of mostly well-formed traffic
	task automatic test_random(int count);
		int r;
		kind_t k;
		logic [15:0] slots;
		for (int j = 0; j < count; j++) begin
			r = $urandom_range(0, 99);
			k = r < 35 ? KIND_ADD : r < 50 ? KIND_STOP : r < 60 ? KIND_LOAD : KIND_TICK;
			slots = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 4));
			send_command(k, $urandom_range(0, 9) == 0 ? $urandom :
				sub_pool[$urandom_range(0, 23)], 2'($urandom), slots,
				$urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 8)),
				$urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 8)),
				$urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 8)));
		end
		drain();
	endtask

	initial begin
		for (int j = 0; j < 24; j++) sub_pool[j] = $urandom;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_add_stop();
		test_full();
		test_expiry();
		test_refill();
		test_threshold();
		write_reg(CFG_FREE_NEED, 16'h01FF);
		write_reg(CFG_EXPIRY, 16'd6);
		test_random(40);
		write_reg(CFG_FREE_NEED, 16'd3);
		write_reg(CFG_ANY_TRAFFIC, 16'd1);
		write_reg(CFG_HALF_RATE, 16'd1);
		write_reg(CFG_EXPIRY, 16'd1);
		test_random(40);
		write_reg(CFG_FREE_NEED, 16'h0100);
		write_reg(CFG_ANY_TRAFFIC, 16'd0);
		write_reg(CFG_HALF_RATE, 16'd0);
		write_reg(CFG_EXPIRY, 16'd12);
		test_random(40);
		if (fails == 0 && pending_events.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
